// ----- src/swdg_pkg.sv -----
// Package for the sliding-window deviation grade block.
// Holds the channel payload types, register codes and fixed field widths.
// No dependencies.
`default_nettype none

package swdg_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int WLEN_BITS   = 7;
  localparam int SCALE_BITS  = 32;
  localparam int GRADE_BITS  = 16;

  // Register reset values
  localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 7'd3;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 32'd65536;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WINDOW_LEN  = 1'b0,
    CFG_GRADE_SCALE = 1'b1
  } cfg_idx_t;

  // Input transaction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [GRADE_BITS-1:0] grade_value;
    logic                  flat;
    logic                  last_out;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/swdg_fifo.sv -----
// Small synchronous queue carrying window sums from the front to the back.
// Standalone; depth must be a power of two.
`default_nettype none

module swdg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/swdg_front.sv -----
// Front end: accepts samples, pads the stream ends, keeps the sample ring and
// walks the window of every graded position into sum and sum of squares.
// Depends on swdg_pkg.
`default_nettype none

module swdg_front #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire swdg_pkg::in_item_t                in_data,
  input  wire logic [swdg_pkg::WLEN_BITS-1:0]    window_len,
  output logic                                   job_push,
  input  wire logic                              job_full,
  output logic [3*swdg_pkg::SAMPLE_BITS+3*$clog2(WINDOW_MAX+1)-1:0] job_data
);

  localparam int SB = swdg_pkg::SAMPLE_BITS;
  localparam int AW = $clog2(WINDOW_MAX);
  localparam int WB = $clog2(WINDOW_MAX + 1);
  localparam int SW = SB + WB;
  localparam int QW = 2 * SB - 1 + WB;

  typedef enum logic [2:0] {F_IDLE, F_PUSH, F_WALK, F_DRAIN, F_ENQ} fstate_t;
  typedef enum logic [1:0] {K_PRE, K_SAMP, K_POST} kind_t;

  fstate_t              state_r, state_nxt;
  kind_t                kind_r, kind_nxt;
  logic [WB-1:0]        pads_r, pads_nxt;
  logic signed [SB-1:0] smp_r, smp_nxt;
  logic                 last_r, last_nxt;
  logic [WB-1:0]        w_r, w_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [WB-1:0]        fill_r, fill_nxt;
  logic [6:0]           seen_r, seen_nxt;
  logic [6:0]           emit_r, emit_nxt;
  logic [AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [WB-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic signed [SB-1:0] rdata_r;
  logic signed [SW-1:0] s_acc_r, s_acc_nxt;
  logic [QW-1:0]        q_acc_r, q_acc_nxt;
  logic                 job_last_r, job_last_nxt;

  logic signed [SB-1:0] mem_r [WINDOW_MAX];

  logic [WB-1:0]          w_eff;
  logic [WB-1:0]          fill_inc;
  logic [6:0]             seen_inc;
  logic [6:0]             pending;
  logic                   do_emit;
  logic                   final_push;
  logic                   adv;
  logic signed [2*SB-1:0] sq_prod;

  assign in_full  = (state_r != F_IDLE);
  assign job_data = {s_acc_r, q_acc_r, w_r, job_last_r};

  // Clamp the window length register to the supported range
  always_comb begin
    if (window_len < 7'd2) begin
      w_eff = WB'(2);
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      w_eff = WB'(WINDOW_MAX);
    end else begin
      w_eff = WB'(window_len);
    end
  end

  // Per-push bookkeeping
  assign fill_inc   = (fill_r == WB'(WINDOW_MAX)) ? fill_r : fill_r + 1'b1;
  assign seen_inc   = (kind_r == K_SAMP) ? seen_r + 7'd1 : seen_r;
  assign pending    = seen_inc - emit_r;
  assign do_emit    = (fill_inc >= w_r) && (pending != 7'd0);
  assign final_push = ((kind_r == K_SAMP) && !last_r) ||
                      ((kind_r == K_POST) && (pads_r == WB'(1)));
  assign sq_prod    = rdata_r * rdata_r;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    pads_nxt     = pads_r;
    smp_nxt      = smp_r;
    last_nxt     = last_r;
    w_nxt        = w_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    seen_nxt     = seen_r;
    emit_nxt     = emit_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_cnt_nxt   = rd_cnt_r;
    rd_vld_nxt   = 1'b0;
    s_acc_nxt    = s_acc_r;
    q_acc_nxt    = q_acc_r;
    job_last_nxt = job_last_r;
    job_push     = 1'b0;
    adv          = 1'b0;

    // accumulate data read in the previous cycle
    if (rd_vld_r) begin
      s_acc_nxt = s_acc_r + SW'(rdata_r);
      q_acc_nxt = q_acc_r + QW'(unsigned'(sq_prod));
    end

    unique case (state_r)
      F_IDLE: begin
        if (in_push) begin
          smp_nxt  = in_data.sample;
          last_nxt = in_data.last;
          w_nxt    = w_eff;
          if (fill_r == '0) begin
            kind_nxt = K_PRE;
            pads_nxt = w_eff >> 1;
          end else begin
            kind_nxt = K_SAMP;
          end
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        wp_nxt   = (wp_r == AW'(WINDOW_MAX - 1)) ? '0 : wp_r + 1'b1;
        fill_nxt = fill_inc;
        seen_nxt = seen_inc;
        if (do_emit) begin
          emit_nxt     = emit_r + 7'd1;
          job_last_nxt = last_r && (final_push || (pending == 7'd1));
          rd_ptr_nxt   = wp_r;
          rd_cnt_nxt   = w_r;
          s_acc_nxt    = '0;
          q_acc_nxt    = '0;
          state_nxt    = F_WALK;
        end else begin
          adv = 1'b1;
        end
      end
      F_WALK: begin
        rd_vld_nxt = 1'b1;
        rd_ptr_nxt = (rd_ptr_r == '0) ? AW'(WINDOW_MAX - 1) : rd_ptr_r - 1'b1;
        rd_cnt_nxt = rd_cnt_r - 1'b1;
        if (rd_cnt_r == WB'(1)) begin
          state_nxt = F_DRAIN;
        end
      end
      F_DRAIN: begin
        state_nxt = F_ENQ;
      end
      F_ENQ: begin
        if (!job_full) begin
          job_push = 1'b1;
          adv      = 1'b1;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase

    // move to the next push of this item, or finish it
    if (adv) begin
      state_nxt = F_PUSH;
      unique case (kind_r)
        K_PRE: begin
          if (pads_r == WB'(1)) begin
            kind_nxt = K_SAMP;
          end else begin
            pads_nxt = pads_r - 1'b1;
          end
        end
        K_SAMP: begin
          if (last_r) begin
            kind_nxt = K_POST;
            pads_nxt = w_r >> 1;
          end else begin
            state_nxt = F_IDLE;
          end
        end
        K_POST: begin
          if (pads_r == WB'(1)) begin
            state_nxt = F_IDLE;
          end else begin
            pads_nxt = pads_r - 1'b1;
          end
        end
        default: begin
          state_nxt = F_IDLE;
        end
      endcase
      // stream end returns the counters to reset
      if (state_nxt == F_IDLE && last_r) begin
        fill_nxt = '0;
        seen_nxt = '0;
        emit_nxt = '0;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      kind_r   <= K_SAMP;
      pads_r   <= '0;
      wp_r     <= '0;
      fill_r   <= '0;
      seen_r   <= '0;
      emit_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      kind_r   <= kind_nxt;
      pads_r   <= pads_nxt;
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      seen_r   <= seen_nxt;
      emit_r   <= emit_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    smp_r      <= smp_nxt;
    last_r     <= last_nxt;
    w_r        <= w_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    s_acc_r    <= s_acc_nxt;
    q_acc_r    <= q_acc_nxt;
    job_last_r <= job_last_nxt;
  end

  // Sample ring: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == F_PUSH) begin
      mem_r[wp_r] <= smp_r;
    end
    if (state_r == F_WALK) begin
      rdata_r <= mem_r[rd_ptr_r];
    end
  end

endmodule

`default_nettype wire

// ----- src/swdg_back.sv -----
// Back end: turns window sums into w*Q - S*S, takes its integer square root
// one bit pair a cycle, scales it and holds the result for the receiver.
// Depends on swdg_pkg.
`default_nettype none

module swdg_back #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              job_empty,
  output logic                                   job_pop,
  input  wire logic [3*swdg_pkg::SAMPLE_BITS+3*$clog2(WINDOW_MAX+1)-1:0] job_data,
  input  wire logic [swdg_pkg::SCALE_BITS-1:0]   grade_scale,
  input  wire logic                              out_pop,
  output logic                                   out_empty,
  output swdg_pkg::out_item_t                    out_data
);

  localparam int SB = swdg_pkg::SAMPLE_BITS;
  localparam int WB = $clog2(WINDOW_MAX + 1);
  localparam int SW = SB + WB;
  localparam int QW = 2 * SB - 1 + WB;
  localparam int DW = QW + WB;
  localparam int RW = (DW + 1) / 2;
  localparam int CW = $clog2(RW + 1);
  localparam int PW = RW + 32;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUB, B_SQRT, B_PLO, B_PHI, B_OUT} bstate_t;

  bstate_t              state_r, state_nxt;
  logic signed [SW-1:0] s_r, s_nxt;
  logic [QW-1:0]        q_r, q_nxt;
  logic [WB-1:0]        w_r, w_nxt;
  logic                 last_r, last_nxt;
  logic [DW-1:0]        wq_r, wq_nxt;
  logic [2*SW-1:0]      sq_r, sq_nxt;
  logic [DW-1:0]        x_r, x_nxt;
  logic [DW:0]          root_r, root_nxt;
  logic [DW:0]          bit_r, bit_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [RW+15:0]       plo_r, plo_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic                 ovld_r, ovld_nxt;
  swdg_pkg::out_item_t  odata_r, odata_nxt;

  logic [SW-1:0]        mag;
  logic [DW:0]          trial;
  logic [RW-1:0]        root;
  logic [RW+15:0]       phi;

  assign out_empty = !ovld_r;
  assign out_data  = odata_r;
  assign mag       = s_r[SW-1] ? SW'(-s_r) : SW'(s_r);
  assign trial     = root_r + bit_r;
  assign root      = root_r[RW-1:0];
  assign phi       = root * grade_scale[31:16];

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    q_nxt     = q_r;
    w_nxt     = w_r;
    last_nxt  = last_r;
    wq_nxt    = wq_r;
    sq_nxt    = sq_r;
    x_nxt     = x_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    plo_nxt   = plo_r;
    prod_nxt  = prod_r;
    ovld_nxt  = ovld_r && !out_pop;
    odata_nxt = odata_r;
    job_pop   = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop                      = 1'b1;
          {s_nxt, q_nxt, w_nxt, last_nxt} = job_data;
          state_nxt                    = B_MUL;
        end
      end
      // w*Q and S*S
      B_MUL: begin
        wq_nxt    = w_r * q_r;
        sq_nxt    = mag * mag;
        state_nxt = B_SUB;
      end
      B_SUB: begin
        x_nxt     = ((2*SW)'(wq_r) >= sq_r) ? DW'((2*SW)'(wq_r) - sq_r) : '0;
        root_nxt  = '0;
        bit_nxt   = (DW + 1)'(1) << (2 * (RW - 1));
        cnt_nxt   = CW'(RW);
        state_nxt = B_SQRT;
      end
      // restoring square root, one result bit per cycle
      B_SQRT: begin
        if ((DW + 1)'(x_r) >= trial) begin
          x_nxt    = DW'((DW + 1)'(x_r) - trial);
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = B_PLO;
        end
      end
      // scale multiply in two 16-bit halves
      B_PLO: begin
        plo_nxt   = root * grade_scale[15:0];
        state_nxt = B_PHI;
      end
      B_PHI: begin
        prod_nxt  = PW'(plo_r) + {phi, 16'd0};
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!ovld_r || out_pop) begin
          ovld_nxt              = 1'b1;
          odata_nxt.grade_value = (|prod_r[PW-1:24]) ? 16'hFFFF : prod_r[23:8];
          odata_nxt.flat        = ~|prod_r[PW-1:16];
          odata_nxt.last_out    = last_r;
          state_nxt             = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    s_r     <= s_nxt;
    q_r     <= q_nxt;
    w_r     <= w_nxt;
    last_r  <= last_nxt;
    wq_r    <= wq_nxt;
    sq_r    <= sq_nxt;
    x_r     <= x_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    cnt_r   <= cnt_nxt;
    plo_r   <= plo_nxt;
    prod_r  <= prod_nxt;
    odata_r <= odata_nxt;
  end

endmodule

`default_nettype wire

// ----- src/sliding_window_deviation_grade_core.sv -----
// Sliding-window deviation grade, top level.
// Depends on swdg_pkg, swdg_front, swdg_fifo and swdg_back.
//
// Usage:
//  - Input queue port: write a sample with in_push while in_full is low. The
//    front takes one sample at a time; in_full stays high while it pads the
//    stream ends and walks windows.
//  - Result queue port: a grade waits on out_data while out_empty is low and
//    leaves with out_pop. A stalled receiver backs up the back end, then the
//    two-entry sum queue, then the front.
//  - Config port: cfg_valid/cfg_ready (always ready), cfg_index selects
//    window_len or grade_scale. Write only while no transaction is in flight.
//  - Timing: the front accepts a sample, then makes one push for it and one
//    per pad. Each graded position adds a front walk (w ring reads, drain,
//    enqueue) and a back pass (23 root bits, 6 other stages) that overlaps
//    the next walk; the slower side sets the pace.
//  - Reset: counters cleared, no stream in progress, registers at defaults.
//    The sample ring needs no clearing.
`default_nettype none

module sliding_window_deviation_grade_core #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire swdg_pkg::in_item_t              in_data,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output swdg_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire swdg_pkg::cfg_idx_t              cfg_index,
  input  wire logic [swdg_pkg::SCALE_BITS-1:0] cfg_data
);

  localparam int WB = $clog2(WINDOW_MAX + 1);
  localparam int JW = 3 * swdg_pkg::SAMPLE_BITS + 3 * WB;

  logic [swdg_pkg::WLEN_BITS-1:0]  window_len_r;
  logic [swdg_pkg::SCALE_BITS-1:0] grade_scale_r;
  logic                            job_push, job_full, job_pop, job_empty;
  logic [JW-1:0]                   job_wdata, job_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r  <= swdg_pkg::WLEN_RESET;
      grade_scale_r <= swdg_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swdg_pkg::CFG_WINDOW_LEN:  window_len_r  <= cfg_data[swdg_pkg::WLEN_BITS-1:0];
        swdg_pkg::CFG_GRADE_SCALE: grade_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  swdg_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .window_len (window_len_r),
    .job_push   (job_push),
    .job_full   (job_full),
    .job_data   (job_wdata)
  );

  swdg_fifo #(.WIDTH(JW), .DEPTH(2)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_wdata),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_rdata)
  );

  swdg_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .job_data    (job_rdata),
    .grade_scale (grade_scale_r),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_data    (out_data)
  );

`ifndef ASSERT_OFF
  a_jobq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && job_full))
    else $error("window sums pushed into a full queue");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("front took a second sample while busy");

  a_flat_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.flat) |-> (out_data.grade_value < 16'd256))
    else $error("flat result with grade of 1.0 or more");
`endif

endmodule

`default_nettype wire

// ----- tb/sliding_window_deviation_grade_core_tb.sv -----
// Testbench for sliding_window_deviation_grade_core: directed rows, then random streams
// over several register settings, checked against an in-bench window grade predictor.
// Depends on swdg_pkg and the core RTL only.
`default_nettype none

module sliding_window_deviation_grade_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WMAX        = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 300;
  localparam int HOLD_CYCLES = 3000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  swdg_pkg::in_item_t              in_data = '0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  swdg_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  swdg_pkg::cfg_idx_t              cfg_index = swdg_pkg::CFG_WINDOW_LEN;
  logic [swdg_pkg::SCALE_BITS-1:0] cfg_data = '0;

  sliding_window_deviation_grade_core #(.WINDOW_MAX(WMAX)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state and register copies
  logic [swdg_pkg::WLEN_BITS-1:0]  win_len_reg = swdg_pkg::WLEN_RESET;
  logic [swdg_pkg::SCALE_BITS-1:0] scale_reg   = swdg_pkg::SCALE_RESET;
  int                              win_store[WMAX];
  int unsigned                     win_fill, seen_cnt, graded_cnt;
  swdg_pkg::out_item_t             grade_q[$];   // grades still owed by the block
  swdg_pkg::out_item_t             step_q[$];    // grades caused by the current sample

  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  bit  hold_req = 1'b0;

  function automatic int unsigned eff_len();
    if (win_len_reg < 2) return 2;
    if (win_len_reg > WMAX) return WMAX;
    return win_len_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Grade the newest w stored samples
  function automatic swdg_pkg::out_item_t grade_window(int unsigned w);
    longint signed       sx;
    longint unsigned     sxx, mag, wq, sq, d, prod, q;
    swdg_pkg::out_item_t g;
    sx = 0;
    sxx = 0;
    for (int i = WMAX - w; i < WMAX; i++) begin
      sx  += win_store[i];
      sxx += longint'(win_store[i]) * longint'(win_store[i]);
    end
    mag  = (sx < 0) ? -sx : sx;
    wq   = w * sxx;
    sq   = mag * mag;
    d    = (wq >= sq) ? wq - sq : 0;
    prod = int_sqrt(d) * longint'(scale_reg);
    q    = prod >> 8;
    g.grade_value = (q > 65535) ? 16'hFFFF : q[15:0];
    g.flat        = (prod < 65536);
    g.last_out    = 1'b0;
    return g;
  endfunction

  function automatic void shift_sample(int v, int unsigned w);
    for (int i = 0; i < WMAX - 1; i++) win_store[i] = win_store[i+1];
    win_store[WMAX-1] = v;
    if (win_fill < WMAX) win_fill++;
    if (win_fill >= w && ((seen_cnt - graded_cnt) & 7'h7F) != 0) begin
      step_q = {step_q, grade_window(w)};
      graded_cnt = (graded_cnt + 1) & 7'h7F;
    end
  endfunction

  // Fills step_q with the grades one accepted sample causes
  function automatic void predict_grades(swdg_pkg::in_item_t it);
    int unsigned w, h;
    int          s;
    w = eff_len();
    h = w / 2;
    s = $signed(it.sample);
    step_q.delete();
    if (win_fill == 0)
      for (int i = 0; i < h; i++) shift_sample(s, w);
    seen_cnt = (seen_cnt + 1) & 7'h7F;
    shift_sample(s, w);
    if (it.last) begin
      for (int i = 0; i < h; i++) shift_sample(s, w);
      if (step_q.size() > 0) step_q[step_q.size()-1].last_out = 1'b1;
      seen_cnt = 0;
      graded_cnt = 0;
      win_fill = 0;
    end
  endfunction

  // Send one sample; returns at a falling edge, sometimes after a random idle gap
  task automatic send_sample(swdg_pkg::in_item_t it, bit typed,
                             swdg_pkg::out_item_t typed_res);
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    predict_grades(it);
    if (typed) grade_q = {grade_q, typed_res};
    else grade_q = {grade_q, step_q};
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  task automatic write_reg(swdg_pkg::cfg_idx_t idx, logic [swdg_pkg::SCALE_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == swdg_pkg::CFG_WINDOW_LEN) win_len_reg = val[swdg_pkg::WLEN_BITS-1:0];
    else scale_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain outstanding grades, then let the block settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (grade_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic swdg_pkg::in_item_t rand_sample(bit last);
    swdg_pkg::in_item_t it;
    it.sample = ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 16)) - 8)
                                            : 16'($urandom);
    it.last   = last;
    return it;
  endfunction

  // Random streams, each closed by a last sample
  task automatic run_streams(int n_items, int max_len);
    int left, len;
    swdg_pkg::out_item_t none;
    none = '0;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_sample(rand_sample(i == len - 1), 1'b0, none);
      left -= len;
    end
  endtask

  task automatic set_regs(logic [swdg_pkg::WLEN_BITS-1:0] w,
                          logic [swdg_pkg::SCALE_BITS-1:0] sc);
    write_reg(swdg_pkg::CFG_WINDOW_LEN, {25'($urandom), w});
    write_reg(swdg_pkg::CFG_GRADE_SCALE, sc);
  endtask

  // Directed rows at reset settings (w = 3, scale = 1.0)
  typedef struct {
    logic signed [15:0]  sample;
    bit                  last;
    bit                  typed;
    swdg_pkg::out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows[16] = '{
    // one-sample streams: flat window, zero grade
    '{16'sh7FFF, 1, 1, '{16'd0, 1'b1, 1'b1}},
    '{16'sh8000, 1, 1, '{16'd0, 1'b1, 1'b1}},
    '{16'sh0000, 1, 1, '{16'd0, 1'b1, 1'b1}},
    '{16'shFFFF, 1, 1, '{16'd0, 1'b1, 1'b1}},
    // alternating extremes: saturated grade
    '{16'sh8000, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh7FFF, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh8000, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh7FFF, 1, 0, '{16'd0, 1'b0, 1'b0}},
    // small steps near the flat threshold
    '{16'sh0005, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh0005, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh0006, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh0005, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'shFFFB, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'sh0007, 1, 0, '{16'd0, 1'b0, 1'b0}},
    // two-sample stream
    '{16'sh1234, 0, 0, '{16'd0, 1'b0, 1'b0}},
    '{16'shEDCC, 1, 0, '{16'd0, 1'b0, 1'b0}}
  };

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (grade_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected grade: got %h/%b/%b", out_data.grade_value,
                   out_data.flat, out_data.last_out);
      end else begin
        if (out_data !== grade_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("grade mismatch: exp %h/%b/%b got %h/%b/%b",
                     grade_q[0].grade_value, grade_q[0].flat, grade_q[0].last_out,
                     out_data.grade_value, out_data.flat, out_data.last_out);
        end
        void'(grade_q.pop_front());
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int pct;
    bit hold_done;
    pct = 100;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (cycle_cnt % 64 == 0) pct = ($urandom_range(0, 2) == 0) ? 100 :
                                       ($urandom_range(0, 1) ? 70 : 30);
        out_pop <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    swdg_pkg::in_item_t it;
    for (int i = 0; i < WMAX; i++) win_store[i] = 0;
    win_fill = 0;
    seen_cnt = 0;
    graded_cnt = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      it.sample = dir_rows[i].sample;
      it.last   = dir_rows[i].last;
      send_sample(it, dir_rows[i].typed, dir_rows[i].res);
    end
    wait_idle();

    set_regs(7'd2, 32'd0);
    run_streams(10, 8);
    wait_idle();

    // widest window, max scale; long receiver hold fills the block
    set_regs(7'd64, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    run_streams(15, 20);
    wait_idle();

    set_regs(7'd0, 32'd256);
    run_streams(10, 8);
    wait_idle();

    set_regs(7'd127, 32'd65536);
    run_streams(10, 12);
    wait_idle();

    set_regs(7'd1, $urandom);
    run_streams(10, 8);
    wait_idle();

    set_regs(7'($urandom_range(2, 64)), $urandom_range(0, 32'h00FF_FFFF));
    run_streams(15, 10);
    wait_idle();

    // stream long enough to wrap the 7-bit position counters
    set_regs(7'($urandom_range(2, 8)), $urandom_range(1024, 262144));
    for (int i = 0; i < 130; i++) send_sample(rand_sample(i == 129), 1'b0, '0);
    wait_idle();

    if (mismatch_cnt == 0 && grade_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
